[src/ioc_pkg.sv]
package ioc_pkg;

    localparam int DATA_W   = 16;
    localparam int NUM_AXES = 6;
    localparam int AXIS_W   = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_SAMPLE = 2'd1;
    localparam logic [1:0] OP_START  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DISCARD   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_TOL = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GYRO_TOL  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_DIV = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_GYRO_DIV  = 3'd5;

    localparam logic [12:0] RST_WINDOW    = 13'd1000;
    localparam logic [9:0]  RST_DISCARD   = 10'd100;
    localparam logic [7:0]  RST_ACCEL_TOL = 8'd10;
    localparam logic [7:0]  RST_GYRO_TOL  = 8'd5;
    localparam logic [7:0]  RST_ACCEL_DIV = 8'd8;
    localparam logic [7:0]  RST_GYRO_DIV  = 8'd4;

    localparam logic signed [17:0] ONE_G = 18'sd16384;
    localparam logic [AXIS_W-1:0] AXIS_AZ   = 3'd2;
    localparam logic [AXIS_W-1:0] AXIS_LAST = 3'd5;
    localparam logic [AXIS_W-1:0] AXIS_GX   = 3'd3;

    localparam logic KIND_APPLY = 1'b0;
    localparam logic KIND_DONE  = 1'b1;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_FIRST,
        PH_ADJ
    } ioc_phase_t;

    typedef enum logic [2:0] {
        ST_RUN,
        ST_DIV1_GO,
        ST_DIV1_WAIT,
        ST_DIV2_GO,
        ST_DIV2_WAIT,
        ST_FIN,
        ST_EMIT
    } ioc_state_t;

    typedef struct packed {
        logic [1:0]               opcode;
        logic [2:0]               axis_select;
        logic signed [DATA_W-1:0] initial_offset;
        logic signed [DATA_W-1:0] sample_ax;
        logic signed [DATA_W-1:0] sample_ay;
        logic signed [DATA_W-1:0] sample_az;
        logic signed [DATA_W-1:0] sample_gx;
        logic signed [DATA_W-1:0] sample_gy;
        logic signed [DATA_W-1:0] sample_gz;
    } ioc_in_t;

    typedef struct packed {
        logic                     result_kind;
        logic                     success;
        logic signed [DATA_W-1:0] out_ax;
        logic signed [DATA_W-1:0] out_ay;
        logic signed [DATA_W-1:0] out_az;
        logic signed [DATA_W-1:0] out_gx;
        logic signed [DATA_W-1:0] out_gy;
        logic signed [DATA_W-1:0] out_gz;
    } ioc_out_t;

    typedef struct packed {
        logic              load_off;
        logic              step;
        logic              clear_win;
        logic              div_go;
        logic              div_adj;
        logic              cap_mean;
        logic              upd;
        logic              first;
        logic              load_out;
        logic              out_kind;
        logic              out_success;
        logic [AXIS_W-1:0] axis;
    } ioc_cmd_t;

    typedef struct packed {
        logic at_last;
        logic div_done;
        logic in_band;
    } ioc_stat_t;

endpackage

[src/ioc_div.sv]
module ioc_div
    import ioc_pkg::*;
#(
    parameter int DW  = 28,
    parameter int DVW = 13
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [DW-1:0]  dividend,
    input  logic [DVW-1:0] divisor,
    output logic           done,
    output logic [DW-1:0]  quotient
);

    localparam int CW = $clog2(DW + 1);

    logic [DW-1:0]  q_reg;
    logic [DVW-1:0] rem_reg;
    logic [DVW-1:0] dvs_reg;
    logic [CW-1:0]  cnt_reg;
    logic           run_reg;
    logic           done_reg;
    logic [DVW:0]   shifted;
    logic           fits;

    assign shifted = {rem_reg, q_reg[DW-1]};
    assign fits    = shifted >= {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= run_reg && (cnt_reg == CW'(1));
            if (start && !run_reg) begin
                run_reg <= 1'b1;
                cnt_reg <= CW'(DW);
            end else if (run_reg) begin
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1)) begin
                    run_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk) begin
        if (start && !run_reg) begin
            q_reg   <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end else if (run_reg) begin
            q_reg   <= {q_reg[DW-2:0], fits};
            rem_reg <= fits ? DVW'(shifted - {1'b0, dvs_reg}) : shifted[DVW-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

[src/ioc_datapath.sv]
module ioc_datapath
    import ioc_pkg::*;
#(
    parameter int MAX_WINDOW = 4096
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  ioc_in_t               req,
    input  ioc_cmd_t              cmd,
    output ioc_stat_t             stat,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output ioc_out_t              rsp
);

    localparam int WIN_W = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W = DATA_W + $clog2(MAX_WINDOW);
    localparam int CNT_W = ((WIN_W > 10) ? WIN_W : 10) + 1;
    localparam int DVW   = (WIN_W > 9) ? WIN_W : 9;

    logic [12:0] ws_reg;
    logic [9:0]  dc_reg;
    logic [7:0]  at_reg, gt_reg, afd_reg, gfd_reg;

    logic signed [SUM_W-1:0]  sums_reg [NUM_AXES];
    logic signed [DATA_W-1:0] wo_reg   [NUM_AXES];
    logic signed [DATA_W-1:0] so_reg   [NUM_AXES];
    logic signed [DATA_W-1:0] samp     [NUM_AXES];
    logic [CNT_W-1:0]         cnt_reg;
    logic signed [DATA_W-1:0] mean_reg;
    logic                     neg_reg;
    ioc_out_t                 rsp_reg;

    logic [WIN_W-1:0]         win;
    logic [CNT_W-1:0]         last;
    logic                     in_range;
    logic                     accel;
    logic signed [17:0]       dev;
    logic [16:0]              dev_mag;
    logic [7:0]               tol;
    logic [8:0]               div9;
    logic signed [SUM_W-1:0]  sum_sel;
    logic [SUM_W-1:0]         sum_mag;
    logic [SUM_W-1:0]         dvd;
    logic [DVW-1:0]           dvs;
    logic                     div_done;
    logic [SUM_W-1:0]         quot;
    logic [DATA_W-1:0]        q16;
    logic signed [DATA_W-1:0] qs;

    assign samp[0] = req.sample_ax;
    assign samp[1] = req.sample_ay;
    assign samp[2] = req.sample_az;
    assign samp[3] = req.sample_gx;
    assign samp[4] = req.sample_gy;
    assign samp[5] = req.sample_gz;

    always_comb begin
        if (ws_reg == 13'd0) begin
            win = WIN_W'(1);
        end else if (32'(ws_reg) > MAX_WINDOW) begin
            win = WIN_W'(MAX_WINDOW);
        end else begin
            win = WIN_W'(ws_reg);
        end
    end

    assign last     = CNT_W'(dc_reg) + CNT_W'(win);
    assign in_range = (cnt_reg > CNT_W'(dc_reg)) && (cnt_reg <= last);

    // Deviation from the target: one g on the z accelerometer, zero elsewhere.
    assign accel   = cmd.axis < AXIS_GX;
    assign dev     = (cmd.axis == AXIS_AZ) ? ONE_G - 18'(mean_reg) : -18'(mean_reg);
    assign dev_mag = dev[17] ? 17'(-dev) : 17'(dev);
    assign tol     = accel ? at_reg : gt_reg;

    always_comb begin
        if (cmd.first) begin
            if (accel) begin
                div9 = (afd_reg == 8'd0) ? 9'd1 : {1'b0, afd_reg};
            end else begin
                div9 = (gfd_reg == 8'd0) ? 9'd1 : {1'b0, gfd_reg};
            end
        end else begin
            if (accel) begin
                div9 = (at_reg == 8'd0) ? 9'd1 : {1'b0, at_reg};
            end else begin
                div9 = {1'b0, gt_reg} + 9'd1;
            end
        end
    end

    assign sum_sel = sums_reg[cmd.axis];
    assign sum_mag = sum_sel[SUM_W-1] ? SUM_W'(-sum_sel) : SUM_W'(sum_sel);
    assign dvd     = cmd.div_adj ? SUM_W'(dev_mag) : sum_mag;
    assign dvs     = cmd.div_adj ? DVW'(div9) : DVW'(win);

    ioc_div #(
        .DW  (SUM_W),
        .DVW (DVW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_go),
        .dividend (dvd),
        .divisor  (dvs),
        .done     (div_done),
        .quotient (quot)
    );

    // Quotients are wrapped to 16 bits before the sign goes back on.
    assign q16 = quot[DATA_W-1:0];
    assign qs  = neg_reg ? -$signed(q16) : $signed(q16);

    assign stat.at_last  = cnt_reg == last;
    assign stat.div_done = div_done;
    assign stat.in_band  = dev_mag <= 17'(tol);

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            ws_reg  <= RST_WINDOW;
            dc_reg  <= RST_DISCARD;
            at_reg  <= RST_ACCEL_TOL;
            gt_reg  <= RST_GYRO_TOL;
            afd_reg <= RST_ACCEL_DIV;
            gfd_reg <= RST_GYRO_DIV;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_WINDOW:    ws_reg  <= cfg_data;
                CFG_DISCARD:   dc_reg  <= cfg_data[9:0];
                CFG_ACCEL_TOL: at_reg  <= cfg_data[7:0];
                CFG_GYRO_TOL:  gt_reg  <= cfg_data[7:0];
                CFG_ACCEL_DIV: afd_reg <= cfg_data[7:0];
                CFG_GYRO_DIV:  gfd_reg <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            cnt_reg <= '0;
            for (int k = 0; k < NUM_AXES; k++) begin
                sums_reg[k] <= '0;
                wo_reg[k]   <= '0;
                so_reg[k]   <= '0;
            end
        end else begin
            if (cmd.load_off && (req.axis_select <= AXIS_LAST)) begin
                so_reg[req.axis_select] <= req.initial_offset;
            end
            if (cmd.clear_win) begin
                cnt_reg <= '0;
                for (int k = 0; k < NUM_AXES; k++) begin
                    sums_reg[k] <= '0;
                end
            end else if (cmd.step) begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (in_range) begin
                    for (int k = 0; k < NUM_AXES; k++) begin
                        sums_reg[k] <= sums_reg[k] + SUM_W'(samp[k]);
                    end
                end
            end
            if (cmd.upd) begin
                if (cmd.first) begin
                    wo_reg[cmd.axis] <= qs;
                end else if (!stat.in_band) begin
                    wo_reg[cmd.axis] <= wo_reg[cmd.axis] + qs;
                end
            end
        end
    end

    always_ff @(posedge clk) begin
        if (cmd.div_go) begin
            neg_reg <= cmd.div_adj ? dev[17] : sum_sel[SUM_W-1];
        end
        if (cmd.cap_mean) begin
            mean_reg <= qs;
        end
        if (cmd.load_out) begin
            rsp_reg.result_kind <= cmd.out_kind;
            rsp_reg.success     <= cmd.out_success;
            rsp_reg.out_ax      <= wo_reg[0] + so_reg[0];
            rsp_reg.out_ay      <= wo_reg[1] + so_reg[1];
            rsp_reg.out_az      <= wo_reg[2] + so_reg[2];
            rsp_reg.out_gx      <= wo_reg[3] + so_reg[3];
            rsp_reg.out_gy      <= wo_reg[4] + so_reg[4];
            rsp_reg.out_gz      <= wo_reg[5] + so_reg[5];
        end
    end

    assign rsp = rsp_reg;

endmodule

[src/ioc_ctrl.sv]
module ioc_ctrl
    import ioc_pkg::*;
#(
    parameter int MAX_PASSES = 5
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    input  logic [1:0] req_opcode,
    output logic      req_stall,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    input  ioc_stat_t stat,
    output ioc_cmd_t  cmd
);

    localparam int PASS_W = $clog2(MAX_PASSES + 1);

    ioc_state_t        state_reg, state_next;
    ioc_phase_t        phase_reg;
    logic [PASS_W-1:0] pass_reg;
    logic [PASS_W-1:0] pass_inc;
    logic [AXIS_W-1:0] axis_reg;
    logic [NUM_AXES-1:0] ready_reg;
    logic              kind_reg;
    logic              succ_reg;
    logic              out_valid_reg;
    logic              in_fire;
    logic              sample_ok;

    assign in_fire   = req_valid && (state_reg == ST_RUN);
    assign sample_ok = in_fire && (req_opcode == OP_SAMPLE) && (phase_reg != PH_IDLE);
    assign pass_inc  = pass_reg + PASS_W'(1);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_RUN: begin
                if (sample_ok && stat.at_last) begin
                    state_next = ST_DIV1_GO;
                end
            end
            ST_DIV1_GO:   state_next = ST_DIV1_WAIT;
            ST_DIV1_WAIT: if (stat.div_done) state_next = ST_DIV2_GO;
            ST_DIV2_GO:   state_next = ST_DIV2_WAIT;
            ST_DIV2_WAIT: begin
                if (stat.div_done) begin
                    state_next = (axis_reg == AXIS_LAST) ? ST_FIN : ST_DIV1_GO;
                end
            end
            ST_FIN:  state_next = ST_EMIT;
            ST_EMIT: if (!out_valid_reg) state_next = ST_RUN;
            default: state_next = ST_RUN;
        endcase
    end

    always_comb begin
        cmd             = '0;
        cmd.axis        = axis_reg;
        cmd.first       = phase_reg == PH_FIRST;
        cmd.out_kind    = kind_reg;
        cmd.out_success = succ_reg;
        unique case (state_reg)
            ST_RUN: begin
                cmd.load_off  = in_fire && (req_opcode == OP_LOAD);
                cmd.clear_win = in_fire && (req_opcode == OP_START);
                cmd.step      = sample_ok;
            end
            ST_DIV1_GO:   cmd.div_go = 1'b1;
            ST_DIV1_WAIT: cmd.cap_mean = stat.div_done;
            ST_DIV2_GO: begin
                cmd.div_go  = 1'b1;
                cmd.div_adj = 1'b1;
            end
            ST_DIV2_WAIT: cmd.upd = stat.div_done;
            ST_FIN:  cmd.clear_win = 1'b1;
            ST_EMIT: cmd.load_out = !out_valid_reg;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg     <= ST_RUN;
            phase_reg     <= PH_IDLE;
            pass_reg      <= '0;
            axis_reg      <= '0;
            ready_reg     <= '0;
            kind_reg      <= KIND_APPLY;
            succ_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cmd.clear_win && (state_reg == ST_RUN)) begin
                phase_reg <= PH_FIRST;
                pass_reg  <= '0;
            end
            if (state_reg == ST_RUN) begin
                axis_reg  <= '0;
                ready_reg <= '0;
            end
            if (cmd.upd) begin
                ready_reg[axis_reg] <= stat.in_band;
                axis_reg            <= axis_reg + AXIS_W'(1);
            end
            if (state_reg == ST_FIN) begin
                if (phase_reg == PH_FIRST) begin
                    kind_reg  <= KIND_APPLY;
                    succ_reg  <= 1'b0;
                    phase_reg <= PH_ADJ;
                end else if (&ready_reg) begin
                    kind_reg  <= KIND_DONE;
                    succ_reg  <= 1'b1;
                    phase_reg <= PH_IDLE;
                    pass_reg  <= '0;
                end else if (32'(pass_inc) >= MAX_PASSES) begin
                    kind_reg  <= KIND_DONE;
                    succ_reg  <= 1'b0;
                    phase_reg <= PH_IDLE;
                    pass_reg  <= '0;
                end else begin
                    kind_reg <= KIND_APPLY;
                    succ_reg <= 1'b0;
                    pass_reg <= pass_inc;
                end
            end
            if (cmd.load_out) begin
                out_valid_reg <= 1'b1;
            end else if (out_valid_reg && !rsp_stall) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign req_stall = state_reg != ST_RUN;
    assign rsp_valid = out_valid_reg;

    a_emit_only_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_EMIT))
        else $error("result raised outside the emit step");

    a_mean_then_adjust: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV1_WAIT && stat.div_done) |=> (state_reg == ST_DIV2_GO))
        else $error("mean division not followed by adjustment division");

    a_compute_while_calibrating: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV1_GO || state_reg == ST_DIV1_WAIT ||
         state_reg == ST_DIV2_GO || state_reg == ST_DIV2_WAIT) |-> (phase_reg != PH_IDLE))
        else $error("window computation while idle");

endmodule

[src/imu_offset_calibrator_core.sv]
// Offset calibrator for a six-axis motion sensor.
// The req channel carries one transaction per command: load an initial offset,
// deliver a sample, or start calibration. Each is taken while req_stall is low.
// The transaction that carries the last sample of a window starts the window-end
// computation: six axes, each with a mean division and an adjustment division
// on one shared restoring divider that retires one quotient bit per cycle.
// req_stall stays high through the computation; rsp_valid rises in the same cycle
// that req_stall falls. The rsp channel then presents the offsets from an output
// register. New transactions are taken while a result waits; a result finished
// while the previous one is still stalled holds the block until rsp is taken.
// The cfg channel writes a register by index at any time; cfg_ready is always
// high. Writes are meant to happen only while the block is idle.
// Reset clears all offsets, sums and counters, restores the register defaults
// and leaves the block idle with rsp_valid low.
module imu_offset_calibrator_core
    import ioc_pkg::*;
#(
    parameter int MAX_WINDOW = 4096,
    parameter int MAX_PASSES = 5
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_stall,
    input  ioc_in_t               req,
    output logic                  rsp_valid,
    input  logic                  rsp_stall,
    output ioc_out_t              rsp,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    ioc_cmd_t  cmd;
    ioc_stat_t stat;

    assign cfg_ready = 1'b1;

    ioc_ctrl #(
        .MAX_PASSES (MAX_PASSES)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_opcode (req.opcode),
        .req_stall  (req_stall),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .stat       (stat),
        .cmd        (cmd)
    );

    ioc_datapath #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .stat      (stat),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .rsp       (rsp)
    );

endmodule

[bench/imu_offset_calibrator_core_test.sv]
module imu_offset_calibrator_core_test
    import ioc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WIN_LIMIT   = 4096;
    localparam int PASS_LIMIT  = 5;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int SETTLE      = 500;
    localparam int HOLD_OFF    = 3000;

    typedef struct {
        ioc_in_t  item;
        bit       typed;
        ioc_out_t want;
    } stim_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  req_valid;
    logic                  req_stall;
    ioc_in_t               req;
    logic                  rsp_valid;
    logic                  rsp_stall;
    ioc_out_t              rsp;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    imu_offset_calibrator_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Predictor state and its copy of the registers.
    logic [12:0]        reg_window;
    logic [9:0]         reg_discard;
    logic [7:0]         reg_accel_tol;
    logic [7:0]         reg_gyro_tol;
    logic [7:0]         reg_accel_div;
    logic [7:0]         reg_gyro_div;
    ioc_phase_t         cal_phase;
    int                 win_count;
    longint             axis_acc [NUM_AXES];
    logic signed [15:0] trim [NUM_AXES];
    logic signed [15:0] base_off [NUM_AXES];
    logic [2:0]         pass_cnt;

    ioc_out_t  offsets_due_q[$];
    stim_row_t stim_rows[$];
    int        send_pct;
    int        recv_pct;
    int        hold_left;
    int        cycles;
    int        mismatches;
    int        items_taken;
    int        results_seen;
    int        apply_seen;
    int        done_ok_seen;
    int        done_fail_seen;

    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycles);
            $display("Verification failed");
            $finish;
        end
    end

    function automatic ioc_out_t offsets_now(logic kind, logic ok);
        ioc_out_t r;
        logic signed [15:0] v [NUM_AXES];
        for (int k = 0; k < NUM_AXES; k++)
            v[k] = trim[k] + base_off[k];
        r.result_kind = kind;
        r.success = ok;
        r.out_ax = v[0];
        r.out_ay = v[1];
        r.out_az = v[2];
        r.out_gx = v[3];
        r.out_gy = v[4];
        r.out_gz = v[5];
        return r;
    endfunction

    task automatic predict_calibration(input ioc_in_t it, output bit got, output ioc_out_t r);
        logic signed [15:0] s [NUM_AXES];
        longint mean [NUM_AXES];
        longint win, last, adiv, gdiv, tol, dv, dev, mag;
        int in_band;
        got = 1'b0;
        r = '0;
        s[0] = it.sample_ax;
        s[1] = it.sample_ay;
        s[2] = it.sample_az;
        s[3] = it.sample_gx;
        s[4] = it.sample_gy;
        s[5] = it.sample_gz;
        if (it.opcode == OP_LOAD)
        begin
            if (it.axis_select <= AXIS_LAST)
                base_off[it.axis_select] = it.initial_offset;
            return;
        end
        if (it.opcode == OP_START)
        begin
            cal_phase = PH_FIRST;
            pass_cnt = 0;
            win_count = 0;
            foreach (axis_acc[k]) axis_acc[k] = 0;
            return;
        end
        if (it.opcode != OP_SAMPLE || cal_phase == PH_IDLE)
            return;

        win = reg_window;
        if (win < 1) win = 1;
        if (win > WIN_LIMIT) win = WIN_LIMIT;
        last = reg_discard + win;
        if (win_count > reg_discard && win_count <= last)
            for (int k = 0; k < NUM_AXES; k++)
                axis_acc[k] += s[k];
        if (win_count != last)
        begin
            win_count++;
            return;
        end

        for (int k = 0; k < NUM_AXES; k++)
            mean[k] = axis_acc[k] / win;
        win_count = 0;
        foreach (axis_acc[k]) axis_acc[k] = 0;
        got = 1'b1;

        if (cal_phase == PH_FIRST)
        begin
            adiv = (reg_accel_div != 0) ? reg_accel_div : 1;
            gdiv = (reg_gyro_div != 0) ? reg_gyro_div : 1;
            for (int k = 0; k < NUM_AXES; k++)
            begin
                if (k == AXIS_AZ)
                    trim[k] = 16'((ONE_G - mean[k]) / adiv);
                else if (k < AXIS_GX)
                    trim[k] = 16'((-mean[k]) / adiv);
                else
                    trim[k] = 16'((-mean[k]) / gdiv);
            end
            cal_phase = PH_ADJ;
            r = offsets_now(KIND_APPLY, 1'b0);
            return;
        end

        in_band = 0;
        for (int k = 0; k < NUM_AXES; k++)
        begin
            if (k < AXIS_GX)
            begin
                tol = reg_accel_tol;
                dv = (reg_accel_tol != 0) ? reg_accel_tol : 1;
            end
            else
            begin
                tol = reg_gyro_tol;
                dv = longint'(reg_gyro_tol) + 1;
            end
            dev = (k == AXIS_AZ) ? (ONE_G - mean[k]) : -mean[k];
            mag = (dev < 0) ? -dev : dev;
            if (mag <= tol)
                in_band++;
            else
                trim[k] = 16'(longint'(trim[k]) + dev / dv);
        end

        if (in_band == NUM_AXES)
        begin
            cal_phase = PH_IDLE;
            pass_cnt = 0;
            r = offsets_now(KIND_DONE, 1'b1);
            return;
        end
        pass_cnt = pass_cnt + 1;
        if (pass_cnt >= PASS_LIMIT)
        begin
            cal_phase = PH_IDLE;
            pass_cnt = 0;
            r = offsets_now(KIND_DONE, 1'b0);
            return;
        end
        r = offsets_now(KIND_APPLY, 1'b0);
    endtask

    always @(posedge clk)
    begin
        ioc_out_t e;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            results_seen++;
            if (offsets_due_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result at cycle %0d: %p", cycles, rsp);
            end
            else
            begin
                e = offsets_due_q.pop_front();
                if (rsp.result_kind !== e.result_kind || rsp.success !== e.success ||
                    rsp.out_ax !== e.out_ax || rsp.out_ay !== e.out_ay ||
                    rsp.out_az !== e.out_az || rsp.out_gx !== e.out_gx ||
                    rsp.out_gy !== e.out_gy || rsp.out_gz !== e.out_gz)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch at cycle %0d: expected %p, got %p", cycles, e, rsp);
                end
                else if (e.result_kind == KIND_APPLY)
                    apply_seen++;
                else if (e.success)
                    done_ok_seen++;
                else
                    done_fail_seen++;
            end
        end
    end

    // Receiver: a long hold-off when asked, otherwise random stalls.
    initial
    begin
        rsp_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                rsp_stall <= 1'b1;
                hold_left--;
            end
            else
                rsp_stall <= ($urandom_range(99) < recv_pct);
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(val);
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_WINDOW:    reg_window    = 13'(val);
            CFG_DISCARD:   reg_discard   = 10'(val);
            CFG_ACCEL_TOL: reg_accel_tol = 8'(val);
            CFG_GYRO_TOL:  reg_gyro_tol  = 8'(val);
            CFG_ACCEL_DIV: reg_accel_div = 8'(val);
            CFG_GYRO_DIV:  reg_gyro_div  = 8'(val);
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_calibration(input int unsigned w, d, at, gt, ad, gd);
        write_reg(CFG_WINDOW, w);
        write_reg(CFG_DISCARD, d);
        write_reg(CFG_ACCEL_TOL, at);
        write_reg(CFG_GYRO_TOL, gt);
        write_reg(CFG_ACCEL_DIV, ad);
        write_reg(CFG_GYRO_DIV, gd);
    endtask

    task automatic send_item(input ioc_in_t it, input bit typed, input ioc_out_t want);
        bit got;
        ioc_out_t r;
        @(negedge clk);
        while ($urandom_range(99) < send_pct)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        req <= it;
        do @(posedge clk); while (req_stall);
        items_taken++;
        predict_calibration(it, got, r);
        if (typed)
            offsets_due_q.push_back(want);
        else if (got)
            offsets_due_q.push_back(r);
    endtask

    // Lets the block drain and finish any window-end computation in flight.
    task automatic drain;
        @(negedge clk);
        req_valid <= 1'b0;
        while (offsets_due_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    function automatic ioc_in_t mk_item(logic [1:0] op, logic [2:0] ax, logic [15:0] off,
                                        logic [15:0] a, b, c, d, e, f);
        ioc_in_t it;
        it.opcode = op;
        it.axis_select = ax;
        it.initial_offset = off;
        it.sample_ax = a;
        it.sample_ay = b;
        it.sample_az = c;
        it.sample_gx = d;
        it.sample_gy = e;
        it.sample_gz = f;
        return it;
    endfunction

    function automatic ioc_out_t mk_out(logic kind, logic ok, logic [15:0] a, b, c, d, e, f);
        ioc_out_t r;
        r.result_kind = kind;
        r.success = ok;
        r.out_ax = a;
        r.out_ay = b;
        r.out_az = c;
        r.out_gx = d;
        r.out_gy = e;
        r.out_gz = f;
        return r;
    endfunction

    function automatic void add_row(ioc_in_t it, bit typed = 1'b0, ioc_out_t want = '0);
        stim_row_t row;
        row.item = it;
        row.typed = typed;
        row.want = want;
        stim_rows.push_back(row);
    endfunction

    function automatic logic [15:0] sample_value(int k);
        int target;
        int pick;
        target = (k == AXIS_AZ) ? 16384 : 0;
        pick = $urandom_range(99);
        if (pick < 60)
            return 16'(target + int'($urandom_range(80)) - 40);
        else if (pick < 85)
            return 16'($urandom);
        else
            return $urandom_range(1) ? 16'h7fff : 16'h8000;
    endfunction

    task automatic run_random(input int count);
        ioc_in_t it;
        int pick;
        bit counts;
        while (count > 0)
        begin
            pick = $urandom_range(99);
            it = mk_item(OP_SAMPLE, 3'($urandom), 16'($urandom), sample_value(0),
                         sample_value(1), sample_value(2), sample_value(3),
                         sample_value(4), sample_value(5));
            if (cal_phase == PH_IDLE && pick < 50)
                it.opcode = OP_START;
            else if (pick < 3)
                it.opcode = OP_START;
            else if (pick < 8)
                it.opcode = OP_LOAD;
            else if (pick < 10)
                it.opcode = 2'd3;
            counts = (it.opcode == OP_START) ||
                     (it.opcode == OP_LOAD && it.axis_select <= AXIS_LAST) ||
                     (it.opcode == OP_SAMPLE && cal_phase != PH_IDLE);
            send_item(it, 1'b0, '0);
            if (counts)
                count--;
        end
    endtask

    initial
    begin
        ioc_in_t hi_all, lo_all;
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        cycles = 0;
        mismatches = 0;
        items_taken = 0;
        results_seen = 0;
        apply_seen = 0;
        done_ok_seen = 0;
        done_fail_seen = 0;
        send_pct = 0;
        recv_pct = 0;
        hold_left = 0;

        reg_window = RST_WINDOW;
        reg_discard = RST_DISCARD;
        reg_accel_tol = RST_ACCEL_TOL;
        reg_gyro_tol = RST_GYRO_TOL;
        reg_accel_div = RST_ACCEL_DIV;
        reg_gyro_div = RST_GYRO_DIV;
        cal_phase = PH_IDLE;
        win_count = 0;
        pass_cnt = 0;
        foreach (trim[k])
        begin
            trim[k] = 0;
            base_off[k] = 0;
            axis_acc[k] = 0;
        end

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        // Directed part: one-sample windows with the other registers at reset values.
        hi_all = mk_item(OP_SAMPLE, 3'd0, 16'h0, 16'h7fff, 16'h7fff, 16'h7fff,
                         16'h7fff, 16'h7fff, 16'h7fff);
        lo_all = mk_item(OP_SAMPLE, 3'd0, 16'h0, 16'h8000, 16'h8000, 16'h8000,
                         16'h8000, 16'h8000, 16'h8000);
        write_reg(CFG_WINDOW, 1);
        write_reg(CFG_DISCARD, 0);
        add_row(hi_all);
        add_row(mk_item(2'd3, 3'd7, 16'hffff, 16'hffff, 16'hffff, 16'hffff,
                        16'hffff, 16'hffff, 16'hffff));
        add_row(mk_item(OP_LOAD, 3'd6, 16'h8000, 0, 0, 0, 0, 0, 0));
        add_row(mk_item(OP_LOAD, 3'd7, 16'h7fff, 0, 0, 0, 0, 0, 0));
        add_row(mk_item(OP_LOAD, 3'd0, 16'h7fff, 0, 0, 0, 0, 0, 0));
        add_row(mk_item(OP_LOAD, 3'd1, 16'h8000, 0, 0, 0, 0, 0, 0));
        add_row(mk_item(OP_START, 3'd0, 16'h0, 0, 0, 0, 0, 0, 0));
        add_row(lo_all);
        add_row(mk_item(OP_SAMPLE, 3'd0, 16'h0, 0, 0, 0, 0, 0, 0), 1'b1,
                mk_out(KIND_APPLY, 1'b0, 16'h7fff, 16'h8000, 16'h0800, 0, 0, 0));
        add_row(hi_all);
        // Exactly one g on z and nothing elsewhere puts every axis in band.
        add_row(mk_item(OP_SAMPLE, 3'd0, 16'h0, 0, 0, 16'd16384, 0, 0, 0), 1'b1,
                mk_out(KIND_DONE, 1'b1, 16'h7fff, 16'h8000, 16'h0800, 0, 0, 0));
        add_row(mk_item(OP_START, 3'd0, 16'h0, 0, 0, 0, 0, 0, 0));
        add_row(lo_all);
        add_row(hi_all);
        // A start in the middle of calibration begins a fresh first window.
        add_row(mk_item(OP_START, 3'd0, 16'h0, 0, 0, 0, 0, 0, 0));
        add_row(hi_all);
        add_row(lo_all);
        for (int p = 0; p < PASS_LIMIT; p++)
        begin
            add_row(lo_all);
            add_row(hi_all);
        end
        foreach (stim_rows[i])
            send_item(stim_rows[i].item, stim_rows[i].typed, stim_rows[i].want);
        drain();

        set_calibration(1, 0, 10, 5, 8, 4);
        run_random(150);
        drain();

        send_pct = 48;
        set_calibration(3, 1, 255, 255, 255, 255);
        run_random(150);
        drain();

        send_pct = 0;
        recv_pct = 48;
        set_calibration(0, 2, 1, 0, 1, 1);
        run_random(150);
        drain();

        send_pct = 6;
        recv_pct = 6;
        set_calibration(2, 0, 0, 0, 0, 0);
        hold_left = HOLD_OFF;
        run_random(150);
        drain();

        send_pct = 0;
        recv_pct = 0;
        set_calibration(5, 3, 20, 10, 3, 2);
        run_random(150);
        drain();

        // Oversized window and longest discard: only the start of a window is reached.
        set_calibration(8191, 1023, 255, 255, 255, 255);
        run_random(60);
        drain();

        $display("Accepted %0d transactions, checked %0d results", items_taken, results_seen);
        $display("Offset updates %0d, converged %0d, pass limit hit %0d",
                 apply_seen, done_ok_seen, done_fail_seen);
        if (mismatches == 0 && offsets_due_q.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

[imu_offset_calibrator_core.f]
src/ioc_pkg.sv
src/ioc_div.sv
src/ioc_datapath.sv
src/ioc_ctrl.sv
src/imu_offset_calibrator_core.sv
bench/imu_offset_calibrator_core_test.sv
